[rtl/wss_pkg.sv]
`timescale 1ns / 1ps

package wss_pkg;

  localparam int MaxPattern = 16;
  localparam int MaxText    = 65536;
  localparam int PosWidth   = 17;
  localparam int LenWidth   = 5;
  localparam int IdxWidth   = 16;
  localparam int CfgIdxWidth = 3;
  localparam int CfgDataWidth = 64;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5a;
  localparam logic [7:0] CharLowerA = 8'h61;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegPatternLow    = 3'd0,
    RegPatternHigh   = 3'd1,
    RegPatternLength = 3'd2,
    RegFoldCase      = 3'd3,
    RegStartIndex    = 3'd4,
    RegEndIndex      = 3'd5
  } cfg_reg_t;

  typedef logic [MaxPattern-1:0][7:0] window_t;

  typedef struct packed {
    window_t             pattern;
    logic [LenWidth-1:0] pattern_length;
    logic                fold_case;
    logic [IdxWidth-1:0] start_index;
    logic [16:0]         end_index;
  } cfg_t;

  typedef struct packed {
    logic                hit;
    logic [IdxWidth-1:0] start;
  } match_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= CharUpperA && c <= CharUpperZ) begin
      r = c - CharUpperA + CharLowerA;
    end
    return r;
  endfunction

endpackage

[rtl/wss_if.sv]
`timescale 1ns / 1ps

interface wss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface wss_out_if;
  logic                          valid;
  logic                          ready;
  logic                          match_found;
  logic [wss_pkg::IdxWidth-1:0]  match_index;

  modport source (output valid, output match_found, output match_index, input ready);
  modport sink (input valid, input match_found, input match_index, output ready);
endinterface

interface wss_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [wss_pkg::CfgIdxWidth-1:0]   index;
  logic [wss_pkg::CfgDataWidth-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/wss_cfg_regs.sv]
`timescale 1ns / 1ps

module wss_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  wss_cfg_if.sink       cfg,
  output wss_pkg::cfg_t cfg_q
);

  logic [63:0]                   pattern_low;
  logic [63:0]                   pattern_high;
  logic [wss_pkg::LenWidth-1:0]  pattern_length;
  logic                          fold_case;
  logic [wss_pkg::IdxWidth-1:0]  start_index;
  logic [16:0]                   end_index;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      fold_case      <= 1'b0;
      start_index    <= '0;
      end_index      <= '1;
    end else if (cfg.valid) begin
      case (wss_pkg::cfg_reg_t'(cfg.index))
        wss_pkg::RegPatternLow:    pattern_low    <= cfg.data;
        wss_pkg::RegPatternHigh:   pattern_high   <= cfg.data;
        wss_pkg::RegPatternLength: pattern_length <= cfg.data[wss_pkg::LenWidth-1:0];
        wss_pkg::RegFoldCase:      fold_case      <= cfg.data[0];
        wss_pkg::RegStartIndex:    start_index    <= cfg.data[wss_pkg::IdxWidth-1:0];
        wss_pkg::RegEndIndex:      end_index      <= cfg.data[16:0];
        default: ;
      endcase
    end
  end

  assign cfg_q.pattern        = {pattern_high, pattern_low};
  assign cfg_q.pattern_length = pattern_length;
  assign cfg_q.fold_case      = fold_case;
  assign cfg_q.start_index    = start_index;
  assign cfg_q.end_index      = end_index;

endmodule

[rtl/wss_matcher.sv]
`timescale 1ns / 1ps

module wss_matcher (
  input  wss_pkg::cfg_t                cfg_q,
  input  wss_pkg::window_t             window,
  input  logic [7:0]                   text_byte,
  input  logic [wss_pkg::PosWidth-1:0] pos,
  output wss_pkg::window_t             window_next,
  output wss_pkg::match_t              match
);

  logic [wss_pkg::LenWidth-1:0] len;
  logic [3:0]                   len_m1;
  logic [wss_pkg::PosWidth-1:0] pos_next;
  logic [wss_pkg::PosWidth-1:0] s;
  logic                         long_enough;
  logic                         start_ok;
  logic                         end_ok;
  logic [wss_pkg::MaxPattern-1:0] eq;

  assign len = (cfg_q.pattern_length > wss_pkg::LenWidth'(wss_pkg::MaxPattern)) ?
               wss_pkg::LenWidth'(wss_pkg::MaxPattern) : cfg_q.pattern_length;
  assign len_m1 = 4'(len - wss_pkg::LenWidth'(1));

  assign pos_next = pos + wss_pkg::PosWidth'(1);

  always_comb begin
    window_next[0] = text_byte;
    for (int k = 1; k < wss_pkg::MaxPattern; k++) begin
      window_next[k] = window[k-1];
    end
  end

  assign s           = pos_next - wss_pkg::PosWidth'(len);
  assign long_enough = pos_next >= wss_pkg::PosWidth'(len);
  assign start_ok    = s >= wss_pkg::PosWidth'(cfg_q.start_index);
  // any negative end index leaves only the text end as the limit
  assign end_ok      = cfg_q.end_index[16] || (s <= cfg_q.end_index);

  // pattern byte j lines up with the window entry len-1-j, newest at 0
  always_comb begin
    for (int j = 0; j < wss_pkg::MaxPattern; j++) begin
      eq[j] = (5'(j) >= len) ||
              (wss_pkg::fold(window_next[4'(len_m1 - 4'(j))], cfg_q.fold_case) ==
               wss_pkg::fold(cfg_q.pattern[j], cfg_q.fold_case));
    end
  end

  assign match.hit   = (len != '0) && long_enough && start_ok && end_ok && (&eq);
  assign match.start = s[wss_pkg::IdxWidth-1:0];

endmodule

[rtl/windowed_substring_search_unit.sv]
`timescale 1ns / 1ps

// channel     direction  transfer carries
// text_in     in         text_byte, end_of_text
// result_out  out        match_found, match_index
// cfg         in         index, data (register write)
//
// one text byte per cycle; a byte is registered on entry, checked against
// the pattern while it is held there by a parallel 16-byte window compare
// and, if it ends the text, its result lands in the output register.
// synchronous reset clears valid flags and per-text state, resets config.
// a stalled result only holds back the item that ends the next text.

module windowed_substring_search_unit (
  input  logic       clk,
  input  logic       rst,
  wss_in_if.sink     text_in,
  wss_out_if.source  result_out,
  wss_cfg_if.sink    cfg
);

  wss_pkg::cfg_t    cfg_q;
  wss_pkg::window_t window;
  wss_pkg::window_t window_next;
  wss_pkg::match_t  match;

  logic                         in_valid;
  logic [7:0]                   in_byte;
  logic                         in_eot;

  logic [wss_pkg::PosWidth-1:0] pos;
  logic                         have_match;
  logic [wss_pkg::IdxWidth-1:0] first_start;

  logic                         out_valid;
  logic                         out_found;
  logic [wss_pkg::IdxWidth-1:0] out_index;

  logic                         content;
  logic                         take;
  logic                         last;
  logic                         advance;
  logic                         out_free;
  logic                         have_match_next;
  logic [wss_pkg::IdxWidth-1:0] first_start_next;

  wss_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  wss_matcher u_matcher (
    .cfg_q       (cfg_q),
    .window      (window),
    .text_byte   (in_byte),
    .pos         (pos),
    .window_next (window_next),
    .match       (match)
  );

  assign content = in_byte != 8'd0;
  // bytes past the maximum text length are dropped
  assign take    = content && (pos < wss_pkg::PosWidth'(wss_pkg::MaxText));
  assign last    = in_eot || !content;

  assign out_free = !out_valid || result_out.ready;
  assign advance  = in_valid && (!last || out_free);
  assign text_in.ready = !in_valid || advance;

  assign have_match_next  = have_match || (take && match.hit);
  assign first_start_next = (!have_match && take && match.hit) ? match.start : first_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text_in.ready) begin
      in_valid <= text_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.ready && text_in.valid) begin
      in_byte <= text_in.text_byte;
      in_eot  <= text_in.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window      <= '0;
      pos         <= '0;
      have_match  <= 1'b0;
      first_start <= '0;
    end else if (advance) begin
      if (last) begin
        window      <= '0;
        pos         <= '0;
        have_match  <= 1'b0;
        first_start <= '0;
      end else if (take) begin
        window      <= window_next;
        pos         <= pos + wss_pkg::PosWidth'(1);
        have_match  <= have_match_next;
        first_start <= first_start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // the terminating byte itself is checked when it is content
  always_ff @(posedge clk) begin
    if (advance && last) begin
      out_found <= have_match_next;
      out_index <= have_match_next ? first_start_next : '0;
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.match_found = out_found;
  assign result_out.match_index = out_index;

endmodule

[bench/wss_search_checker.sv]
`timescale 1ns / 1ps

module wss_search_checker
  import wss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [7:0]              in_byte,
  input  logic                    in_eot,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    out_found,
  input  logic [IdxWidth-1:0]     out_index,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  output int                      errors,
  output int                      pending
);

  cfg_t                shadow;
  window_t             recent;
  int                  text_len;
  logic                seen_hit;
  logic [IdxWidth-1:0] hit_start;
  match_t              results_due[$];

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    if (shadow.fold_case && c >= CharUpperA && c <= CharUpperZ) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  task automatic clear_text();
    recent    = '0;
    text_len  = 0;
    seen_hit  = 1'b0;
    hit_start = '0;
  endtask

  task automatic store_register(input logic [CfgIdxWidth-1:0] idx,
                                input logic [CfgDataWidth-1:0] data);
    case (idx)
      RegPatternLow:    shadow.pattern[7:0] = data;
      RegPatternHigh:   shadow.pattern[15:8] = data;
      RegPatternLength: shadow.pattern_length = data[LenWidth-1:0];
      RegFoldCase:      shadow.fold_case = data[0];
      RegStartIndex:    shadow.start_index = data[IdxWidth-1:0];
      RegEndIndex:      shadow.end_index = data[16:0];
      default: ;
    endcase
  endtask

  // shift a byte in, match a pattern ending on it, queue results at text end
  task automatic take_text_item(input logic [7:0] b, input logic eot);
    int     len;
    int     s;
    logic   same;
    logic   closes;
    match_t outcome;
    closes = eot;
    if (b == 8'h00) begin
      closes = 1'b1;
    end else if (text_len < MaxText) begin
      recent = {recent[MaxPattern-2:0], b};
      text_len++;
      len = (shadow.pattern_length > MaxPattern) ? MaxPattern : int'(shadow.pattern_length);
      if (!seen_hit && len != 0 && text_len >= len) begin
        s = text_len - len;
        if (s >= int'(shadow.start_index) &&
            (shadow.end_index[16] || s <= int'(shadow.end_index[15:0]))) begin
          same = 1'b1;
          for (int j = 0; j < len; j++) begin
            if (fold_byte(recent[len-1-j]) != fold_byte(shadow.pattern[j])) begin
              same = 1'b0;
            end
          end
          if (same) begin
            seen_hit  = 1'b1;
            hit_start = s[IdxWidth-1:0];
          end
        end
      end
    end
    if (closes) begin
      outcome.hit   = seen_hit;
      outcome.start = seen_hit ? hit_start : '0;
      results_due.push_back(outcome);
      clear_text();
    end
  endtask

  task automatic check_result(input logic found, input logic [IdxWidth-1:0] index);
    match_t want;
    if (results_due.size() == 0) begin
      errors++;
      $display("%0t: result expected none actual found=%0b index=%0d",
               $time, found, index);
    end else begin
      want = results_due.pop_front();
      if (found !== want.hit) begin
        errors++;
        $display("%0t: match_found expected %0b actual %0b", $time, want.hit, found);
      end
      if (index !== want.start) begin
        errors++;
        $display("%0t: match_index expected %0d actual %0d", $time, want.start, index);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow = '0;
      shadow.end_index = 17'h1ffff;
      clear_text();
      results_due.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        store_register(cfg_index, cfg_data);
      end
      // a result never comes back in the cycle its text ends, so compare first
      if (out_valid && out_ready) begin
        check_result(out_found, out_index);
      end
      if (in_valid && in_ready) begin
        take_text_item(in_byte, in_eot);
      end
    end
    pending = results_due.size();
  end

endmodule

[bench/tb_windowed_substring_search_unit.sv]
`timescale 1ns / 1ps

module tb_windowed_substring_search_unit;
  import wss_pkg::*;

  typedef logic [7:0] text_q_t[$];

  localparam logic [CfgIdxWidth-1:0] RegSpareA = 3'd6;
  localparam logic [CfgIdxWidth-1:0] RegSpareB = 3'd7;
  localparam logic [16:0] EndOpen         = 17'h1ffff;
  localparam logic [16:0] EndMostNegative = 17'h10000;

  logic    clk;
  logic    rst;
  logic    calm;
  int      sent;
  int      errors;
  int      pending;
  window_t pat;
  int      pat_len;

  wss_in_if  text_ch();
  wss_out_if result_ch();
  wss_cfg_if cfg_ch();

  windowed_substring_search_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_ch),
    .result_out (result_ch),
    .cfg        (cfg_ch)
  );

  wss_search_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (text_ch.valid),
    .in_ready  (text_ch.ready),
    .in_byte   (text_ch.text_byte),
    .in_eot    (text_ch.end_of_text),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_found (result_ch.match_found),
    .out_index (result_ch.match_index),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .errors    (errors),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    result_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 27);
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [63:0] with_junk(input logic [63:0] field, input int w);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    return (junk << w) | field;
  endfunction

  function automatic text_q_t from_str(input string s);
    text_q_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic window_t pat_from_str(input string s);
    window_t p;
    p = '0;
    for (int i = 0; i < s.len() && i < MaxPattern; i++) p[i] = s[i];
    return p;
  endfunction

  // flip the case of letters now and then; zero bytes would end the text
  function automatic logic [7:0] case_jitter(input logic [7:0] c);
    logic [7:0] r;
    r = (c == 8'h00) ? 8'h01 : c;
    if ((r | 8'h20) >= CharLowerA && (r | 8'h20) <= CharLowerA + 8'd25 &&
        $urandom_range(0, 1) == 1) begin
      r = r ^ 8'h20;
    end
    return r;
  endfunction

  task automatic quiesce(input int settle);
    @(negedge clk);
    text_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_search(input window_t p, input int len, input logic fold,
                                input logic [15:0] win_start, input logic [16:0] win_end);
    quiesce(4);
    write_reg(RegPatternLow, p[7:0]);
    write_reg(RegPatternHigh, p[15:8]);
    write_reg(RegPatternLength, with_junk(64'(len[4:0]), LenWidth));
    write_reg(RegFoldCase, with_junk(64'(fold), 1));
    write_reg(RegStartIndex, with_junk(64'(win_start), IdxWidth));
    write_reg(RegEndIndex, with_junk(64'(win_end), 17));
    pat     = p;
    pat_len = (len[4:0] > MaxPattern) ? MaxPattern : int'(len[4:0]);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eot);
    @(negedge clk);
    if (!calm) begin
      while ($urandom_range(0, 99) < 27) begin
        text_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    text_ch.valid       <= 1'b1;
    text_ch.text_byte   <= b;
    text_ch.end_of_text <= eot;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(input text_q_t txt, input logic zero_end);
    foreach (txt[i]) push_byte(txt[i], !zero_end && i == txt.size() - 1);
    if (zero_end || txt.size() == 0) begin
      push_byte(8'h00, 1'($urandom_range(0, 1)));
    end
  endtask

  // mostly pattern pieces and planted copies so that hits are common
  function automatic text_q_t make_text();
    text_q_t t;
    int      n;
    int      r;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
    while (t.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 15 && pat_len > 0) begin
        for (int j = 0; j < pat_len; j++) t.push_back(case_jitter(pat[j]));
      end else if (r < 60 && pat_len > 0) begin
        t.push_back(case_jitter(pat[$urandom_range(0, pat_len - 1)]));
      end else begin
        t.push_back(8'($urandom_range(1, 255)));
      end
    end
    return t;
  endfunction

  task automatic random_setup(input int phase);
    window_t     p;
    int          len;
    int          r;
    logic        fold;
    logic [15:0] s;
    logic [16:0] e;
    for (int j = 0; j < MaxPattern; j++) begin
      r = $urandom_range(0, 49);
      if (r == 0) begin
        p[j] = 8'h00;
      end else if (r < 30) begin
        p[j] = (CharLowerA + 8'($urandom_range(0, 2))) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
      end else begin
        p[j] = 8'($urandom_range(1, 255));
      end
    end
    len  = $urandom_range(0, 20);
    fold = 1'($urandom_range(0, 1));
    s    = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 8));
    case ($urandom_range(0, 3))
      0:       e = EndOpen;
      1:       e = {1'b1, 16'($urandom)};
      2:       e = 17'(s) + 17'($urandom_range(0, 12));
      default: e = 17'($urandom_range(0, 65535));
    endcase
    case (phase)
      0: begin
        for (int j = 0; j < MaxPattern; j++) p[j] = 8'($urandom_range(1, 255));
        len = MaxPattern;
        s   = 16'd0;
        e   = EndOpen;
      end
      1: begin
        len = 31;
        s   = 16'd0;
        e   = 17'd65535;
      end
      2: begin
        len = 1;
        s   = 16'd0;
        e   = 17'd0;
      end
      default: ;
    endcase
    program_search(p, len, fold, s, e);
  endtask

  initial begin
    window_t p;
    int      target;
    clk                 = 1'b0;
    rst                 = 1'b1;
    calm                = 1'b0;
    sent                = 0;
    pat                 = '0;
    pat_len             = 0;
    text_ch.valid       = 1'b0;
    text_ch.text_byte   = 8'h00;
    text_ch.end_of_text = 1'b0;
    result_ch.ready     = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // registers at reset value: empty pattern is never found
    send_text(from_str("a"), 1'b0);
    // hits at 0 and 3 both fall outside the start/end window
    program_search(pat_from_str("abc"), 3, 1'b1, 16'd1, 17'd2);
    send_text(from_str("AbCabc"), 1'b0);
    // no folding: upper case copy is skipped, terminator ends the text
    program_search(pat_from_str("abc"), 3, 1'b0, 16'd0, EndOpen);
    send_text(from_str("zABCabc"), 1'b1);
    send_text(from_str(""), 1'b1);
    // zero byte inside the pattern can never match
    p    = pat_from_str("aab");
    p[1] = 8'h00;
    program_search(p, 3, 1'b0, 16'd0, EndOpen);
    send_text(from_str("aab"), 1'b0);
    // bytes next to the letter ranges, most negative end index
    program_search(pat_from_str("Z"), 1, 1'b1, 16'd0, EndMostNegative);
    send_text(from_str("@[`{zZ"), 1'b0);
    // unused register indexes leave the setup alone
    quiesce(4);
    write_reg(RegSpareA, {$urandom, $urandom});
    write_reg(RegSpareB, {$urandom, $urandom});
    send_text(from_str("Zz"), 1'b0);

    for (int phase = 0; phase < 8; phase++) begin
      calm = (phase == 3);
      random_setup(phase);
      target = sent + 95;
      while (sent < target) begin
        send_text(make_text(), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 19) == 0) quiesce(0);
      end
    end

    calm = 1'b1;
    quiesce(10);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
